// ===== hdl/rsi_pkg.sv =====
package rsi_pkg;

	// Field widths of the request and response items
	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int DIR_W    = 26;
	localparam int DIST_W   = 32;
	localparam int MEAS_W   = 64;

	// Fraction bits of the Q8.24 coordinates and of the Q2.24 direction
	localparam int FRAC_W = 24;

	// Internal widths, sized to the exact value ranges
	localparam int M_W     = COORD_W + 1;           // origin - center
	localparam int MD_W    = M_W + DIR_W;           // one term of m.d
	localparam int DOT_W   = MD_W + 2;              // sum of three terms
	localparam int B_W     = DOT_W - FRAC_W;        // b after the shift
	localparam int BMAG_W  = B_W - 1;               // |b|
	localparam int BHALF_W = BMAG_W / 2;            // split of |b| for squaring
	localparam int MM_W    = 2 * M_W;               // m_i squared
	localparam int RR_W    = 2 * RADIUS_W;          // r squared
	localparam int C_W     = MM_W + 1;              // m.m - r*r
	localparam int BB_W    = 2 * BMAG_W;            // b squared
	localparam int DISC_W  = BB_W + 1;              // b*b - c, signed
	localparam int RAD_W   = BB_W;                  // radicand of the root
	localparam int ROOT_W  = RAD_W / 2;             // one root bit per pair
	localparam int REM_W   = ROOT_W + 4;            // root remainder
	localparam int T_W     = ROOT_W + 3;            // -b +/- root before clamp

endpackage

// ===== hdl/rsi_req_if.sv =====
interface rsi_req_if import rsi_pkg::*; ();

	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  origin_x;
	logic signed [COORD_W-1:0]  origin_y;
	logic signed [COORD_W-1:0]  origin_z;
	logic signed [COORD_W-1:0]  sphere_center_x;
	logic signed [COORD_W-1:0]  sphere_center_y;
	logic signed [COORD_W-1:0]  sphere_center_z;
	logic        [RADIUS_W-1:0] sphere_radius;
	logic signed [DIR_W-1:0]    dir_x;
	logic signed [DIR_W-1:0]    dir_y;
	logic signed [DIR_W-1:0]    dir_z;

	modport source (
		output valid, origin_x, origin_y, origin_z,
		output sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
		output dir_x, dir_y, dir_z,
		input  ready
	);

	modport sink (
		input  valid, origin_x, origin_y, origin_z,
		input  sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
		input  dir_x, dir_y, dir_z,
		output ready
	);

endinterface

// ===== hdl/rsi_rsp_if.sv =====
interface rsi_rsp_if import rsi_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DIST_W-1:0] t_far;
	logic signed [DIST_W-1:0] t_near;
	logic signed [MEAS_W-1:0] inside_measure;

	modport source (
		output valid, hit, t_far, t_near, inside_measure,
		input  ready
	);

	modport sink (
		input  valid, hit, t_far, t_near, inside_measure,
		output ready
	);

endinterface

// ===== hdl/ray_sphere_intersection_unit.sv =====
// Throughput: one item per cycle while the output is not stalled; the square root takes one root bit per stage
// over 36 stages, the products and sums take five stages before it.
// A stalled output holds its stage; bubbles ahead of it fill while it waits.
// Reset (arst_n low) clears every stage valid bit; payload is not reset.
module ray_sphere_intersection_unit import rsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rsi_req_if.sink  req,
	rsi_rsp_if.source rsp
);

	// Stage positions in the valid chain
	localparam int ST_S1 = 0;
	localparam int ST_S2 = 1;
	localparam int ST_S3 = 2;
	localparam int ST_S4 = 3;
	localparam int ST_SQ = 4;                  // discriminant register, root steps follow
	localparam int ST_OUT = ST_SQ + ROOT_W + 1;
	localparam int NST = ST_OUT + 1;

	typedef struct packed {
		logic signed [M_W-1:0]    m_x;
		logic signed [M_W-1:0]    m_y;
		logic signed [M_W-1:0]    m_z;
		logic signed [DIR_W-1:0]  d_x;
		logic signed [DIR_W-1:0]  d_y;
		logic signed [DIR_W-1:0]  d_z;
		logic [RADIUS_W-1:0]      r;
	} diff_t;

	typedef struct packed {
		logic signed [MD_W-1:0] md_x;
		logic signed [MD_W-1:0] md_y;
		logic signed [MD_W-1:0] md_z;
		logic signed [MM_W-1:0] mm_x;
		logic signed [MM_W-1:0] mm_y;
		logic signed [MM_W-1:0] mm_z;
		logic [RR_W-1:0]        rr;
	} prod_t;

	typedef struct packed {
		logic signed [B_W-1:0] b;
		logic signed [C_W-1:0] c;
	} bc_t;

	typedef struct packed {
		logic [2*BHALF_W-1:0]  hh;
		logic [2*BHALF_W-1:0]  hl;
		logic [2*BHALF_W-1:0]  ll;
		logic signed [B_W-1:0] b;
		logic signed [C_W-1:0] c;
	} bpp_t;

	typedef struct packed {
		logic [RAD_W-1:0]         rad;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		logic signed [B_W-1:0]    b;
		logic                     hit;
		logic signed [MEAS_W-1:0] c;
	} sq_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DIST_W-1:0] t_far;
		logic signed [DIST_W-1:0] t_near;
		logic signed [MEAS_W-1:0] meas;
	} res_t;

	// Clamp a root sum to the signed distance range
	function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [T_W-1:0] v);
		logic [T_W-DIST_W:0] top;
		begin
			top = v[T_W-1:DIST_W-1];
			if (top == '0 || top == '1)
				sat_dist = v[DIST_W-1:0];
			else if (v[T_W-1])
				sat_dist = {1'b1, {(DIST_W-1){1'b0}}};
			else
				sat_dist = {1'b0, {(DIST_W-1){1'b1}}};
		end
	endfunction

	// Clamp c to the signed 64-bit measure
	function automatic logic signed [MEAS_W-1:0] sat_meas(input logic signed [C_W-1:0] v);
		logic [C_W-MEAS_W:0] top;
		begin
			top = v[C_W-1:MEAS_W-1];
			if (top == '0 || top == '1)
				sat_meas = v[MEAS_W-1:0];
			else if (v[C_W-1])
				sat_meas = {1'b1, {(MEAS_W-1){1'b0}}};
			else
				sat_meas = {1'b0, {(MEAS_W-1){1'b1}}};
		end
	endfunction

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic [NST-1:0] vld_in;

	diff_t diff_s1;
	prod_t prod_s2;
	bc_t   bc_s3;
	bpp_t  bpp_s4;
	sq_t   sq_s5 [0:ROOT_W];
	res_t  res_q;

	// Valid chain: a stage loads when it is empty or the next one moves
	assign en[NST-1] = !vld_q[NST-1] || rsp.ready;
	genvar k;
	generate
		for (k = 0; k < NST - 1; k++) begin : g_en
			assign en[k] = !vld_q[k] || en[k+1];
		end
	endgenerate

	assign vld_in = {vld_q[NST-2:0], req.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (en[i])
					vld_q[i] <= vld_in[i];
			end
		end
	end

	assign req.ready = en[ST_S1];

	// Stage 1: offset from the sphere center
	always_ff @(posedge clk) begin
		if (en[ST_S1]) begin
			diff_s1.m_x <= M_W'(req.origin_x) - M_W'(req.sphere_center_x);
			diff_s1.m_y <= M_W'(req.origin_y) - M_W'(req.sphere_center_y);
			diff_s1.m_z <= M_W'(req.origin_z) - M_W'(req.sphere_center_z);
			diff_s1.d_x <= req.dir_x;
			diff_s1.d_y <= req.dir_y;
			diff_s1.d_z <= req.dir_z;
			diff_s1.r   <= req.sphere_radius;
		end
	end

	// Stage 2: products for m.d, m.m and r*r
	always_ff @(posedge clk) begin
		if (en[ST_S2]) begin
			prod_s2.md_x <= diff_s1.m_x * diff_s1.d_x;
			prod_s2.md_y <= diff_s1.m_y * diff_s1.d_y;
			prod_s2.md_z <= diff_s1.m_z * diff_s1.d_z;
			prod_s2.mm_x <= diff_s1.m_x * diff_s1.m_x;
			prod_s2.mm_y <= diff_s1.m_y * diff_s1.m_y;
			prod_s2.mm_z <= diff_s1.m_z * diff_s1.m_z;
			prod_s2.rr   <= diff_s1.r * diff_s1.r;
		end
	end

	// Stage 3: sum the products, floor the dot product to Q.24
	logic signed [DOT_W-1:0] dot;
	always_comb begin
		dot = DOT_W'(prod_s2.md_x) + DOT_W'(prod_s2.md_y) + DOT_W'(prod_s2.md_z);
	end

	always_ff @(posedge clk) begin
		if (en[ST_S3]) begin
			bc_s3.b <= B_W'(dot >>> FRAC_W);
			bc_s3.c <= C_W'(prod_s2.mm_x) + C_W'(prod_s2.mm_y) + C_W'(prod_s2.mm_z)
				- C_W'(prod_s2.rr);
		end
	end

	// Stage 4: square |b| as three half-width partial products
	logic [BMAG_W-1:0]  bmag;
	logic [BHALF_W-1:0] bhi;
	logic [BHALF_W-1:0] blo;
	always_comb begin
		bmag = bc_s3.b[B_W-1] ? BMAG_W'(-bc_s3.b) : BMAG_W'(bc_s3.b);
		bhi  = bmag[BMAG_W-1:BHALF_W];
		blo  = bmag[BHALF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[ST_S4]) begin
			bpp_s4.hh <= bhi * bhi;
			bpp_s4.hl <= bhi * blo;
			bpp_s4.ll <= blo * blo;
			bpp_s4.b  <= bc_s3.b;
			bpp_s4.c  <= bc_s3.c;
		end
	end

	// Stage 5: discriminant, hit flag and clamped measure
	logic [BB_W-1:0]          bb;
	logic signed [DISC_W-1:0] disc;
	always_comb begin
		bb = (BB_W'(bpp_s4.hh) << (2 * BHALF_W)) + (BB_W'(bpp_s4.hl) << (BHALF_W + 1))
			+ BB_W'(bpp_s4.ll);
		disc = $signed({1'b0, bb}) - DISC_W'(bpp_s4.c);
	end

	always_ff @(posedge clk) begin
		if (en[ST_SQ]) begin
			sq_s5[0].rad  <= disc[RAD_W-1:0];
			sq_s5[0].rem  <= '0;
			sq_s5[0].root <= '0;
			sq_s5[0].b    <= bpp_s4.b;
			sq_s5[0].hit  <= !disc[DISC_W-1];
			sq_s5[0].c    <= sat_meas(bpp_s4.c);
		end
	end

	// Root steps: one result bit per stage, restoring method
	genvar j;
	generate
		for (j = 0; j < ROOT_W; j++) begin : g_root
			logic [REM_W-1:0] rem_sh;
			logic [REM_W-1:0] trial;
			logic             take;
			always_comb begin
				rem_sh = {sq_s5[j].rem[REM_W-3:0], sq_s5[j].rad[RAD_W-1 -: 2]};
				trial  = {2'b00, sq_s5[j].root, 2'b01};
				take   = rem_sh >= trial;
			end

			always_ff @(posedge clk) begin
				if (en[ST_SQ+1+j]) begin
					sq_s5[j+1].rad  <= {sq_s5[j].rad[RAD_W-3:0], 2'b00};
					sq_s5[j+1].rem  <= take ? rem_sh - trial : rem_sh;
					sq_s5[j+1].root <= {sq_s5[j].root[ROOT_W-2:0], take};
					sq_s5[j+1].b    <= sq_s5[j].b;
					sq_s5[j+1].hit  <= sq_s5[j].hit;
					sq_s5[j+1].c    <= sq_s5[j].c;
				end
			end
		end
	endgenerate

	// Output register: both roots, clamped, zero on a miss
	logic signed [T_W-1:0] nb;
	logic signed [T_W-1:0] rootx;
	logic signed [T_W-1:0] tf;
	logic signed [T_W-1:0] tn;
	always_comb begin
		nb    = -T_W'(sq_s5[ROOT_W].b);
		rootx = T_W'(sq_s5[ROOT_W].root);
		tf    = nb + rootx;
		tn    = nb - rootx;
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			res_q.hit    <= sq_s5[ROOT_W].hit;
			res_q.t_far  <= sq_s5[ROOT_W].hit ? sat_dist(tf) : '0;
			res_q.t_near <= sq_s5[ROOT_W].hit ? sat_dist(tn) : '0;
			res_q.meas   <= sq_s5[ROOT_W].c;
		end
	end

	assign rsp.valid          = vld_q[ST_OUT];
	assign rsp.hit            = res_q.hit;
	assign rsp.t_far          = res_q.t_far;
	assign rsp.t_near         = res_q.t_near;
	assign rsp.inside_measure = res_q.meas;

	// The far root never lies below the near one
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.t_far >= rsp.t_near)
		else $error("t_far below t_near on a hit");

	// A miss carries zero distances
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.t_far == '0 && rsp.t_near == '0)
		else $error("nonzero distance on a miss");

	// Input backpressure only comes from a stalled, full pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready && vld_q == '1)
		else $error("input stalled without a full pipeline");

	// A result held by backpressure stays in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(res_q))
		else $error("stalled result changed");

endmodule
